// ----- design/nsc_pkg.sv -----
// nsc_pkg: shared types and constants of the nal start code splitter
// holds the input and result item payload structs and the stream constants
// no dependencies
package nsc_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned TypeW = 5;
  localparam int unsigned DelayDepth = 4;

  // low five bits of the header byte carry the unit type
  localparam logic [ByteW-1:0] TypeMask = 8'h1f;
  localparam logic [TypeW-1:0] SpsType = 5'd7;

  // start code is 00 00 00 01
  localparam logic [ByteW-1:0] ScZero = 8'h00;
  localparam logic [ByteW-1:0] ScOne = 8'h01;

  // payload of one input item
  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             chunk_end;
  } nsc_in_t;

  // payload of one result item
  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic [TypeW-1:0] unit_type;
    logic             unit_last;
  } nsc_out_t;

endpackage

// ----- design/nsc_if.sv -----
// nsc_if: valid/ready stream interfaces for the input and result channels
// depends on nsc_pkg for the payload structs

// input byte channel
interface nsc_in_if;
  logic             valid;
  logic             ready;
  nsc_pkg::nsc_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// result byte channel
interface nsc_out_if;
  logic              valid;
  logic              ready;
  nsc_pkg::nsc_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- design/nal_start_code_splitter.sv -----
// nal_start_code_splitter: splits an annex b byte stream into nal units
// depends on nsc_pkg and the stream interfaces in nsc_if
//
//   port     role    payload                            dir
//   in_i     sink    data_byte[7:0], chunk_end          in
//   out_o    source  out_byte[7:0], unit_type[4:0],     out
//                    unit_last
//
// one input item per cycle while in_i is not stalled; its result, if any, shows on out_o
// in the cycle after acceptance, from a single result register
// the four-byte delay line and unit state update at the accepting edge
// in_i stalls only while the result register is full and out_o is stalled
// rst_ni clears the delay line, unit state and result valid at once
module nal_start_code_splitter (
  input  logic              clk_i,
  input  logic              rst_ni,
  nsc_in_if.sink            in_i,
  nsc_out_if.source         out_o
);
  import nsc_pkg::*;

  logic [ByteW-1:0] dly_q [DelayDepth];
  logic [ByteW-1:0] dly_d [DelayDepth];
  logic [DelayDepth-1:0] vld_q, vld_d;
  logic             in_unit_q, in_unit_d;
  logic             hdr_pending_q, hdr_pending_d;
  logic [TypeW-1:0] type_q, type_d;
  logic             pass_q, pass_d;
  logic             sps_q, sps_d;
  logic             out_valid_q, out_valid_d;
  nsc_out_t         out_q;

  logic             acc;
  logic             start;
  logic             hdr_take;
  logic             emit;
  logic [ByteW-1:0] b;
  logic [TypeW-1:0] hdr_type;

  // handshake: free result register or one being emptied
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign acc        = in_i.valid && in_i.ready;
  assign b          = in_i.data.data_byte;
  assign hdr_type   = TypeW'(b & TypeMask);

  // start code fills the window after the shift
  assign start = (dly_q[1] == ScZero) && (dly_q[2] == ScZero) &&
                 (dly_q[3] == ScZero) && (b == ScOne);
  assign hdr_take = !start && hdr_pending_q;

  // next unit state
  always_comb begin
    dly_d[0] = dly_q[1];
    dly_d[1] = dly_q[2];
    dly_d[2] = dly_q[3];
    dly_d[3] = b;
    vld_d    = start ? '1 : {in_unit_q, vld_q[DelayDepth-1:1]};
    in_unit_d     = in_unit_q || start;
    hdr_pending_d = start || (hdr_pending_q && !hdr_take);
    type_d = hdr_take ? hdr_type : type_q;
    sps_d  = sps_q || (hdr_take && (hdr_type == SpsType));
    pass_d = hdr_take ? sps_d : pass_q;
  end

  // the oldest byte leaves when valid and its unit is passed
  assign emit = vld_q[0] && pass_d;

  // delay line and unit state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DelayDepth; i++) begin
        dly_q[i] <= '0;
      end
      vld_q         <= '0;
      in_unit_q     <= 1'b0;
      hdr_pending_q <= 1'b0;
      type_q        <= '0;
      pass_q        <= 1'b0;
      sps_q         <= 1'b0;
    end else if (acc) begin
      for (int i = 0; i < DelayDepth; i++) begin
        dly_q[i] <= dly_d[i];
      end
      vld_q         <= vld_d;
      in_unit_q     <= in_unit_d;
      hdr_pending_q <= hdr_pending_d;
      type_q        <= type_d;
      pass_q        <= pass_d;
      sps_q         <= sps_d;
    end
  end

  // result register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (acc) begin
      out_valid_d = emit;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (acc && emit) begin
      out_q.out_byte  <= dly_q[0];
      out_q.unit_type <= type_d;
      out_q.unit_last <= start;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

`ifndef SYNTHESIS
  // a start code always leaves a header byte pending
  a_start_hdr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && start) |=> (hdr_pending_q && in_unit_q))
    else $error("start code did not arm header capture");

  // header capture only inside a unit
  a_hdr_in_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hdr_pending_q |-> in_unit_q)
    else $error("header pending outside a unit");

  // sps flag is sticky
  a_sps_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(sps_q))
    else $error("sps flag cleared");

  // an emitted item belongs to a passed unit
  a_emit_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && emit) |=> (out_valid_q && pass_q && sps_q))
    else $error("item emitted from a dropped unit");
`endif

endmodule

// ----- sim/nal_unit_checker.sv -----
// nal_unit_checker: watches the byte and result channels of the nal start code splitter
// predicts every passed byte with its own model of the splitter and compares in order
// depends on nsc_pkg and the stream interfaces in nsc_if
`timescale 1ns / 1ps

module nal_unit_checker
  import nsc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  nsc_in_if    in_i,
  nsc_out_if   out_i,
  output int   fail_count_o,
  output int   pending_o
);

  // splitter state: delay line, oldest byte at index 0
  logic [ByteW-1:0] line_byte [DelayDepth];
  logic             line_vld  [DelayDepth];
  logic             in_unit;
  logic             pass_unit;
  logic             sps_seen;
  logic [2:0]       unit_off;
  logic [TypeW-1:0] cur_type;

  // passed bytes still to come out, oldest first
  nsc_out_t passed_bytes_q [$];
  int       fails = 0;

  assign fail_count_o = fails;

  // shift one stream byte through the delay line and queue the byte it passes on
  task automatic split_byte(input logic [ByteW-1:0] b);
    logic [ByteW-1:0] leave_b;
    logic             leave_v;
    logic             closes;
    nsc_out_t         res;
    leave_b = line_byte[0];
    leave_v = line_vld[0];
    closes  = 1'b0;
    for (int i = 0; i < DelayDepth - 1; i++) begin
      line_byte[i] = line_byte[i+1];
      line_vld[i]  = line_vld[i+1];
    end
    line_byte[DelayDepth-1] = b;
    line_vld[DelayDepth-1]  = in_unit;

    // start code filling the line closes the unit now leaving
    if (line_byte[0] == ScZero && line_byte[1] == ScZero &&
        line_byte[2] == ScZero && line_byte[3] == ScOne) begin
      closes = 1'b1;
      for (int i = 0; i < DelayDepth; i++) line_vld[i] = 1'b1;
      in_unit  = 1'b1;
      unit_off = 3'd4;
    end else if (in_unit && unit_off == 3'd4) begin
      // header byte, even if it is the first zero of the next start code
      cur_type = TypeW'(b & TypeMask);
      if (cur_type == SpsType) sps_seen = 1'b1;
      pass_unit = sps_seen;
      unit_off  = 3'd5;
    end

    if (leave_v && pass_unit) begin
      res.out_byte  = leave_b;
      res.unit_type = cur_type;
      res.unit_last = closes;
      passed_bytes_q.push_back(res);
    end
  endtask

  // predict on accepted input items, compare accepted result items
  always @(posedge clk_i or negedge rst_ni) begin
    nsc_out_t want;
    nsc_out_t got;
    if (!rst_ni) begin
      for (int i = 0; i < DelayDepth; i++) begin
        line_byte[i] = ScZero;
        line_vld[i]  = 1'b0;
      end
      in_unit   = 1'b0;
      pass_unit = 1'b0;
      sps_seen  = 1'b0;
      unit_off  = 3'd0;
      cur_type  = '0;
      passed_bytes_q.delete();
      pending_o <= 0;
    end else begin
      if (in_i.valid && in_i.ready) split_byte(in_i.data.data_byte);
      if (out_i.valid && out_i.ready) begin
        got = out_i.data;
        if (passed_bytes_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected result, expected none, got byte %02h type %0d last %0b",
                   $time, got.out_byte, got.unit_type, got.unit_last);
        end else begin
          want = passed_bytes_q.pop_front();
          if (got.out_byte !== want.out_byte) begin
            fails++;
            $display("%0t: out_byte mismatch, expected %02h, got %02h",
                     $time, want.out_byte, got.out_byte);
          end
          if (got.unit_type !== want.unit_type) begin
            fails++;
            $display("%0t: unit_type mismatch, expected %0d, got %0d",
                     $time, want.unit_type, got.unit_type);
          end
          if (got.unit_last !== want.unit_last) begin
            fails++;
            $display("%0t: unit_last mismatch, expected %0b, got %0b",
                     $time, want.unit_last, got.unit_last);
          end
        end
      end
      pending_o <= passed_bytes_q.size();
    end
  end

endmodule

// ----- sim/tb_nal_start_code_splitter.sv -----
// tb_nal_start_code_splitter: drives annex b byte streams into the splitter and gives the verdict
// directed units first, then random well-formed units mixed with noise, under varying stalls
// depends on nsc_pkg, nsc_if, the splitter rtl and nal_unit_checker
`timescale 1ns / 1ps

module tb_nal_start_code_splitter;
  import nsc_pkg::*;

  localparam int StreamBytes = 900;

  logic clk_i;
  logic rst_ni;
  int   bytes_sent = 0;
  int   phase = 0;
  int   stall_pct;
  int   fail_count;
  int   pending;

  nsc_in_if  byte_in ();
  nsc_out_if byte_out ();

  nal_start_code_splitter dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (byte_in),
    .out_o  (byte_out)
  );

  nal_unit_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (byte_in),
    .out_i        (byte_out),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // result side backpressure per phase
  assign stall_pct = (phase == 0) ? 51 : (phase == 1) ? 21 : 0;

  always @(posedge clk_i) begin
    byte_out.ready <= ($urandom_range(99) >= stall_pct);
  end

  // stream byte with plenty of zeros so start codes and near misses show up
  function automatic logic [ByteW-1:0] stream_byte();
    if ($urandom_range(3) == 0) return ScZero;
    return ByteW'($urandom_range(255));
  endfunction

  // offer one input item after a random gap and hold it until accepted
  task automatic send_byte(input logic [ByteW-1:0] b, input logic ce);
    int gap_pct;
    gap_pct = (bytes_sent < StreamBytes / 3) ? 21 :
              (bytes_sent < 2 * StreamBytes / 3) ? 51 : 0;
    while ($urandom_range(99) < gap_pct) begin
      byte_in.valid <= 1'b0;
      @(posedge clk_i);
    end
    byte_in.valid <= 1'b1;
    byte_in.data  <= nsc_in_t'{data_byte: b, chunk_end: ce};
    @(posedge clk_i);
    while (!byte_in.ready) @(posedge clk_i);
    bytes_sent++;
    phase <= (bytes_sent < StreamBytes / 3) ? 0 : (bytes_sent < 2 * StreamBytes / 3) ? 1 : 2;
  endtask

  task automatic send_rand_ce(input logic [ByteW-1:0] b);
    send_byte(b, $urandom_range(15) == 0);
  endtask

  // start code, header and payload of one unit
  task automatic send_unit(input logic [ByteW-1:0] header, input int len);
    send_rand_ce(ScZero);
    send_rand_ce(ScZero);
    send_rand_ce(ScZero);
    send_rand_ce(ScOne);
    send_rand_ce(header);
    for (int i = 0; i < len; i++) send_rand_ce(stream_byte());
  endtask

  // stimulus
  initial begin
    int               pick;
    int               len;
    logic [TypeW-1:0] utype;
    rst_ni         = 1'b0;
    byte_in.valid  = 1'b0;
    byte_in.data   = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // noise before the first start code is dropped
    send_byte(8'hff, 1'b1);
    send_byte(ScZero, 1'b0);
    // unit ahead of the first sps is dropped
    send_byte(ScZero, 1'b0);
    send_byte(ScZero, 1'b0);
    send_byte(ScOne, 1'b0);
    send_byte(8'h45, 1'b0);
    send_byte(8'hab, 1'b1);
    send_byte(ScZero, 1'b0);
    // first sps unit, passed from here on
    send_byte(ScZero, 1'b0);
    send_byte(ScZero, 1'b0);
    send_byte(ScOne, 1'b0);
    send_byte(8'h67, 1'b0);
    send_byte(8'hff, 1'b1);
    send_byte(ScZero, 1'b0);
    send_byte(ScZero, 1'b0);
    // start code right after start code, its first zero taken as the header byte
    send_byte(ScZero, 1'b0);
    send_byte(ScZero, 1'b0);
    send_byte(ScOne, 1'b1);
    send_byte(ScZero, 1'b0);
    send_byte(ScZero, 1'b0);
    send_byte(ScZero, 1'b0);
    send_byte(ScOne, 1'b0);
    // header with all type bits set
    send_byte(8'hff, 1'b0);
    send_byte(8'h80, 1'b1);
    send_byte(8'h7f, 1'b0);

    // random units, empty units and noise
    while (bytes_sent < StreamBytes) begin
      pick = $urandom_range(99);
      if (pick < 80) begin
        case ($urandom_range(9))
          0, 1:    utype = SpsType;
          2:       utype = 5'd5;
          default: utype = TypeW'($urandom_range(31));
        endcase
        len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(12);
        send_unit({3'($urandom_range(7)), utype}, len);
      end else if (pick < 90) begin
        send_rand_ce(ScZero);
        send_rand_ce(ScZero);
        send_rand_ce(ScZero);
        send_rand_ce(ScOne);
      end else begin
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++) send_rand_ce(stream_byte());
      end
    end

    // drain, then give any stray result time to show
    byte_in.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #200000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
